/* design/q2e_pkg.sv */
// Shared types, widths and constant tables for the quaternion to Euler angle pipeline.
package q2e_pkg;

    localparam int QUAT_WIDTH_DEF   = 16;
    localparam int ANGLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 14;

    localparam int VEC_W    = 38;   // CORDIC vector datapath, Q.28 with headroom
    localparam int ANG_W    = 34;   // CORDIC angle, Q.30
    localparam int SUM_W    = 36;   // doubled sums of Q.28 products
    localparam int S_W      = 30;   // clamped arcsine argument, Q.28
    localparam int SQ_W     = 58;   // square root radicand and partial root
    localparam int SQ_CELLS = 29;   // one cell for each root bit, radicand below 2^57
    localparam int ATAN_LEN = 30;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [S_W-1:0]   ONE_Q28     = 30'sd268435456;
    localparam logic signed [S_W-1:0]   ASIN_HI_Q28 = 30'sd268432772;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } t_vec;

    typedef struct packed {
        t_vec                  yaw;
        t_vec                  roll;
        logic signed [S_W-1:0] s;
    } t_carry;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] res;
        t_carry          carry;
    } t_sq;

    // atan(2^-i) scaled by 2^30.
    function automatic logic signed [ANG_W-1:0] f_atan(input int idx);
        logic signed [ANG_W-1:0] a;
        case (idx)
            0:  a = 34'sh03243F6A8;
            1:  a = 34'sh01DAC6705;
            2:  a = 34'sh00FADBAFC;
            3:  a = 34'sh007F56EA6;
            4:  a = 34'sh003FEAB76;
            5:  a = 34'sh001FFD55B;
            6:  a = 34'sh000FFFAAA;
            7:  a = 34'sh0007FFF55;
            8:  a = 34'sh0003FFFEA;
            9:  a = 34'sh0001FFFFD;
            10: a = 34'sh0000FFFFF;
            11: a = 34'sh00007FFFF;
            12: a = 34'sh00003FFFF;
            13: a = 34'sh00001FFFF;
            14: a = 34'sh00000FFFF;
            15: a = 34'sh000007FFF;
            16: a = 34'sh000003FFF;
            17: a = 34'sh000001FFF;
            18: a = 34'sh000000FFF;
            19: a = 34'sh0000007FF;
            20: a = 34'sh0000003FF;
            21: a = 34'sh0000001FF;
            22: a = 34'sh0000000FF;
            23: a = 34'sh00000007F;
            24: a = 34'sh00000003F;
            25: a = 34'sh00000001F;
            26: a = 34'sh00000000F;
            27: a = 34'sh000000008;
            28: a = 34'sh000000004;
            29: a = 34'sh000000002;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* design/q2e_isqrt_cell.sv */
// One bit of the pipelined integer square root, carrying the other angle vectors along.
module q2e_isqrt_cell #(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  q2e_pkg::t_sq   i_sq,
    output q2e_pkg::t_sq   o_sq
);
    import q2e_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_CELLS - 1 - K));

    logic [SQ_W-1:0] trial;
    t_sq             n_sq;
    t_sq             r_sq;

    always_comb begin
        trial = i_sq.res + BIT;
        n_sq  = i_sq;
        if (i_sq.v >= trial) begin
            n_sq.v   = i_sq.v - trial;
            n_sq.res = (i_sq.res >> 1) + BIT;
        end else begin
            n_sq.res = i_sq.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

/* design/q2e_cordic_cell.sv */
// One vectoring CORDIC micro-rotation with its own shift and arctangent constant.
module q2e_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  q2e_pkg::t_vec i_vec,
    output q2e_pkg::t_vec o_vec
);
    import q2e_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN = f_atan(IDX);

    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    t_vec                    n_vec;
    t_vec                    r_vec;

    always_comb begin
        x     = i_vec.x;
        y     = i_vec.y;
        dx    = x >>> IDX;
        dy    = y >>> IDX;
        n_vec = i_vec;
        if (!y[VEC_W-1]) begin
            n_vec.x = x + dy;
            n_vec.y = y - dx;
            n_vec.z = i_vec.z + ATAN;
        end else begin
            n_vec.x = x - dy;
            n_vec.y = y + dx;
            n_vec.z = i_vec.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

/* design/quaternion_to_euler_angles.sv */
// Top level: quaternion in, roll, pitch and yaw out through a chain of CORDIC and root cells.
//
//  port group  | direction | beat contents
//  ------------+-----------+-----------------------------------------------
//  i_s_*       | in        | quat_w, quat_x, quat_y, quat_z (Q2.14)
//  o_m_*       | out       | roll_angle, pitch_angle, yaw_angle (Q3.13)
//
// A new beat is taken every cycle unless the output stalls; each beat passes through
// the 29 square root cells and then the CORDIC cells that follow them.
// The whole pipeline advances together whenever the output register is empty or is
// being read, so a stall on the output holds every stage.
// Reset clears only the stage valid bits.
module quaternion_to_euler_angles #(
    parameter int QUAT_WIDTH   = q2e_pkg::QUAT_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = q2e_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF,
    localparam int IN_TW  = ((4 * QUAT_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW = ((3 * ANGLE_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_TW-1:0]  i_s_tdata,   // quat_w, quat_x, quat_y, quat_z, zero pad
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_TW-1:0] o_m_tdata    // roll_angle, pitch_angle, yaw_angle, zero pad
);
    import q2e_pkg::*;

    localparam int QW    = QUAT_WIDTH;
    localparam int AW    = ANGLE_WIDTH;
    localparam int NC    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int PRW   = (2 * QW > 32) ? 2 * QW : 32;
    localparam int SHR   = (2 * QW >= 32) ? 2 * QW - 32 : 0;
    localparam int SHL   = (2 * QW < 32) ? 32 - 2 * QW : 0;
    localparam int LAT   = 3 + SQ_CELLS + NC;
    localparam int RSH   = 33 - AW;
    localparam int RW    = ANG_W + 1;
    localparam logic signed [RW-1:0] RND   = RW'(1) <<< (RSH - 1);
    localparam logic signed [RW-1:0] A_HI  = (RW'(1) <<< (AW - 1)) - RW'(1);
    localparam logic signed [RW-1:0] A_LO  = -A_HI - RW'(1);
    localparam logic [SQ_W-1:0]      ONE_SQ = SQ_W'(1) << 56;

    function automatic logic signed [31:0] f_q28(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
        logic signed [PRW-1:0] p;
        p = PRW'(a) * PRW'(b);
        return 32'((p >>> SHR) <<< SHL);
    endfunction

    function automatic t_vec f_prerot(input logic signed [SUM_W-1:0] yv,
                                      input logic signed [SUM_W-1:0] xv);
        t_vec v;
        v.x    = VEC_W'(xv);
        v.y    = VEC_W'(yv);
        v.z    = '0;
        v.zero = (xv == '0) && (yv == '0);
        if (xv < 0) begin
            if (yv >= 0) begin
                v.x = VEC_W'(yv);
                v.y = -VEC_W'(xv);
                v.z = HALF_PI_Q30;
            end else begin
                v.x = -VEC_W'(yv);
                v.y = VEC_W'(xv);
                v.z = -HALF_PI_Q30;
            end
        end
        return v;
    endfunction

    function automatic logic [AW-1:0] f_round(input t_vec v);
        logic signed [RW-1:0] r;
        r = (RW'(v.z) + RND) >>> RSH;
        if (v.zero) begin
            r = '0;
        end else if (r > A_HI) begin
            r = A_HI;
        end else if (r < A_LO) begin
            r = A_LO;
        end
        return AW'(r);
    endfunction

    logic                    en;
    logic [LAT:0]            r_vld;

    logic signed [QW-1:0]    qw, qx, qy, qz;
    logic signed [31:0]      r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_yz, r_wx, r_xz, r_wy;
    logic signed [SUM_W-1:0] r_yaw_y, r_yaw_x, r_roll_y, r_roll_x;
    logic signed [SUM_W-1:0] s_full;
    logic signed [S_W-1:0]   n_s, r_s;
    logic signed [59:0]      s_sq;
    t_sq                     r_sq0;
    t_sq                     sq_chain [0:SQ_CELLS];
    t_vec                    pitch_in;
    t_vec                    yaw_c   [0:NC];
    t_vec                    roll_c  [0:NC];
    t_vec                    pitch_c [0:NC];
    logic [AW-1:0]           r_roll, r_pitch, r_yaw;

    assign en         = !r_vld[LAT] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT];

    assign qw = i_s_tdata[QW-1:0];
    assign qx = i_s_tdata[2*QW-1:QW];
    assign qy = i_s_tdata[3*QW-1:2*QW];
    assign qz = i_s_tdata[4*QW-1:3*QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:0], i_s_tvalid};
        end
    end

    // Products, doubled sums with the arcsine clamp, then pre-rotation and s squared.
    always_comb begin
        s_full = (SUM_W'(r_wy) - SUM_W'(r_xz)) <<< 1;
        if (s_full > SUM_W'(ASIN_HI_Q28)) begin
            n_s = ASIN_HI_Q28;
        end else if (s_full < -SUM_W'(ONE_Q28)) begin
            n_s = -ONE_Q28;
        end else begin
            n_s = S_W'(s_full);
        end
        s_sq = 60'(r_s) * 60'(r_s);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ww <= f_q28(qw, qw);
            r_xx <= f_q28(qx, qx);
            r_yy <= f_q28(qy, qy);
            r_zz <= f_q28(qz, qz);
            r_xy <= f_q28(qx, qy);
            r_wz <= f_q28(qw, qz);
            r_yz <= f_q28(qy, qz);
            r_wx <= f_q28(qw, qx);
            r_xz <= f_q28(qx, qz);
            r_wy <= f_q28(qw, qy);

            r_yaw_y  <= (SUM_W'(r_xy) + SUM_W'(r_wz)) <<< 1;
            r_yaw_x  <= SUM_W'(r_ww) + SUM_W'(r_xx) - SUM_W'(r_yy) - SUM_W'(r_zz);
            r_roll_y <= (SUM_W'(r_yz) + SUM_W'(r_wx)) <<< 1;
            r_roll_x <= SUM_W'(r_ww) - SUM_W'(r_xx) - SUM_W'(r_yy) + SUM_W'(r_zz);
            r_s      <= n_s;

            r_sq0.v          <= ONE_SQ - SQ_W'(s_sq);
            r_sq0.res        <= '0;
            r_sq0.carry.yaw  <= f_prerot(r_yaw_y, r_yaw_x);
            r_sq0.carry.roll <= f_prerot(r_roll_y, r_roll_x);
            r_sq0.carry.s    <= r_s;
        end
    end

    assign sq_chain[0] = r_sq0;

    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
        q2e_isqrt_cell #(.K(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_sq  (sq_chain[k]),
            .o_sq  (sq_chain[k+1])
        );
    end

    // The root is never negative, so the pitch vector needs no pre-rotation.
    always_comb begin
        pitch_in.x    = VEC_W'(sq_chain[SQ_CELLS].res);
        pitch_in.y    = VEC_W'(sq_chain[SQ_CELLS].carry.s);
        pitch_in.z    = '0;
        pitch_in.zero = 1'b0;
    end

    assign yaw_c[0]   = sq_chain[SQ_CELLS].carry.yaw;
    assign roll_c[0]  = sq_chain[SQ_CELLS].carry.roll;
    assign pitch_c[0] = pitch_in;

    for (genvar i = 0; i < NC; i++) begin : g_cordic
        q2e_cordic_cell #(.IDX(i)) u_yaw (
            .i_clk (i_clk),
            .i_en  (en),
            .i_vec (yaw_c[i]),
            .o_vec (yaw_c[i+1])
        );
        q2e_cordic_cell #(.IDX(i)) u_roll (
            .i_clk (i_clk),
            .i_en  (en),
            .i_vec (roll_c[i]),
            .o_vec (roll_c[i+1])
        );
        q2e_cordic_cell #(.IDX(i)) u_pitch (
            .i_clk (i_clk),
            .i_en  (en),
            .i_vec (pitch_c[i]),
            .o_vec (pitch_c[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= f_round(roll_c[NC]);
            r_pitch <= f_round(pitch_c[NC]);
            r_yaw   <= f_round(yaw_c[NC]);
        end
    end

    assign o_m_tdata = OUT_TW'({r_yaw, r_pitch, r_roll});

endmodule
